[hw/rtl/puct_child_select_macros.svh]
// assertion macros for the puct child select block
// no dependencies
`ifndef PUCT_CHILD_SELECT_MACROS_SVH
`define PUCT_CHILD_SELECT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PCS_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define PCS_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`else
`define PCS_ASSERT_IMP(label, clk, rst, a, c)
`define PCS_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

[hw/rtl/pcs_pkg.sv]
// shared constants for the puct child select block
// no dependencies
package pcs_pkg;
   localparam int VisitsWidth = 20;
   localparam int ValueWidth  = 37;
   localparam int PriorWidth  = 17;
   localparam int GainWidth   = 16;
   localparam int ScoreWidth  = 32;
   localparam int RootWidth   = 16;
   localparam int IndexWidth  = 9;
   localparam int ProdWidth   = GainWidth + PriorWidth + RootWidth; // 49
   localparam logic [GainWidth-1:0] GainReset = 16'd4096;
endpackage

[hw/rtl/puct_child_select.sv]
// puct child selection on one shared shift-subtract unit, one bit per cycle
// uses pcs_pkg and puct_child_select_macros.svh
// sequence, accept to rsp_valid: sqrt on a run's first child only, q div, mul1,
// mul2, explore div, sum, best, out; q div is cut short when the child is unvisited
// one child at a time: req_ready only in idle; out stalls until the response is taken
// reset: synchronous, clears sequencer, run state and loads gain with 1.0
`include "puct_child_select_macros.svh"
module puct_child_select import pcs_pkg::*; #(
   parameter int MAX_CHILDREN = 512
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [GainWidth-1:0]         csr_write_data,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [VisitsWidth-1:0]       req_parent_visits,
   input  logic [VisitsWidth-1:0]       req_child_visits,
   input  logic signed [ValueWidth-1:0] req_child_value_sum,
   input  logic [PriorWidth-1:0]        req_child_prior,
   input  logic                         req_last_child,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [ScoreWidth-1:0] rsp_child_score,
   output logic [IndexWidth-1:0]        rsp_best_index,
   output logic                         rsp_best_valid
);
   localparam int CntWidth = $clog2(MAX_CHILDREN + 1);
   localparam logic [CntWidth-1:0] CntMax = CntWidth'(MAX_CHILDREN);
   // shared unit register width: wide enough for the explore dividend
   localparam int AccWidth = ProdWidth + 2;
   localparam int DivWidth = ProdWidth; // quotient bits for explore

   localparam logic [3:0] StIdle  = 4'd0;
   localparam logic [3:0] StSqrt  = 4'd1;
   localparam logic [3:0] StQdiv  = 4'd2;
   localparam logic [3:0] StMul1  = 4'd3;
   localparam logic [3:0] StMul2  = 4'd4;
   localparam logic [3:0] StEdiv  = 4'd5;
   localparam logic [3:0] StSum   = 4'd6;
   localparam logic [3:0] StBest  = 4'd7;
   localparam logic [3:0] StOut   = 4'd8;

   logic [3:0]              state_ff, state_in;
   logic [5:0]              step_ff, step_in;
   logic [GainWidth-1:0]    gain_ff;
   logic [VisitsWidth-1:0]  cv_ff;
   logic [ValueWidth-1:0]   mag_ff;     // |child sum|
   logic                    neg_ff;
   logic [PriorWidth-1:0]   prior_ff;
   logic                    last_ff;
   logic [RootWidth-1:0]    root_ff, root_in;
   logic [CntWidth-1:0]     cnt_ff, cnt_in;
   logic signed [ScoreWidth-1:0] best_score_ff, best_score_in;
   logic [CntWidth-1:0]     best_pos_ff, best_pos_in;
   // shared shift-subtract unit: remainder, quotient/root, source shifting
   logic [AccWidth-1:0]     rem_ff, rem_in;
   logic [AccWidth-1:0]     quo_ff, quo_in;
   logic [AccWidth-1:0]     src_ff, src_in;
   logic [AccWidth-1:0]     dvs_ff, dvs_in;
   logic signed [ValueWidth:0] q_ff, q_in;
   logic [32:0]             mul_ff, mul_in;
   logic [AccWidth-1:0]     trial;
   logic                    take;
   logic signed [ValueWidth+1:0] sum;
   logic signed [ScoreWidth-1:0] score_ff, score_in;
   logic [ScoreWidth-1:0]   rsp_score_ff;
   logic [IndexWidth-1:0]   rsp_idx_ff;
   logic                    rsp_bv_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == StIdle) && !reset;

   // one subtract-compare per cycle, used by sqrt and both divisions
   always_comb begin
      if (state_ff == StSqrt) begin
         trial = {rem_ff[AccWidth-3:0], src_ff[AccWidth-1 -: 2]}
               - {quo_ff[AccWidth-3:0], 2'b01};
         take  = !trial[AccWidth-1] && (rem_ff[AccWidth-1:AccWidth-2] == 2'b00);
      end else begin
         trial = {rem_ff[AccWidth-2:0], src_ff[AccWidth-1]} - dvs_ff;
         take  = !trial[AccWidth-1];
      end
   end

   always_comb begin
      sum = (ValueWidth+2)'(q_ff) + $signed({1'b0, quo_ff[ValueWidth-1:0]});
      if (quo_ff[AccWidth-1:ValueWidth] != '0 || sum > 39'sd2147483647)
         score_in = 32'sh7fffffff;
      else if (sum < -39'sd2147483648)
         score_in = 32'sh80000000;
      else
         score_in = sum[ScoreWidth-1:0];
   end

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      root_in = root_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      src_in = src_ff;
      dvs_in = dvs_ff;
      q_in = q_ff;
      mul_in = mul_ff;
      cnt_in = cnt_ff;
      best_score_in = best_score_ff;
      best_pos_in = best_pos_ff;
      case (state_ff)
         StIdle: begin
            if (req_valid) begin
               step_in = '0;
               rem_in = '0;
               quo_in = '0;
               if (cnt_ff == '0) begin
                  state_in = StSqrt;
                  // radicand pv<<12 (32 bits) top-aligned, 16 root bits
                  src_in = {req_parent_visits, 12'd0, {(AccWidth-32){1'b0}}};
               end else begin
                  state_in = StQdiv;
                  src_in = {req_child_value_sum[ValueWidth-1]
                     ? ValueWidth'(-req_child_value_sum)
                     : ValueWidth'(req_child_value_sum), {(AccWidth-ValueWidth){1'b0}}};
               end
               dvs_in = AccWidth'(req_child_visits);
            end
         end
         StSqrt: begin
            rem_in = take ? trial : {rem_ff[AccWidth-3:0], src_ff[AccWidth-1 -: 2]};
            quo_in = {quo_ff[AccWidth-2:0], take};
            src_in = {src_ff[AccWidth-3:0], 2'b00};
            step_in = step_ff + 6'd1;
            if (step_ff == 6'd15) begin
               root_in = RootWidth'({quo_ff[AccWidth-2:0], take});
               state_in = StQdiv;
               step_in = '0;
               rem_in = '0;
               quo_in = '0;
               src_in = {mag_ff, {(AccWidth-ValueWidth){1'b0}}};
            end
         end
         StQdiv: begin
            rem_in = take ? trial : {rem_ff[AccWidth-2:0], src_ff[AccWidth-1]};
            quo_in = {quo_ff[AccWidth-2:0], take};
            src_in = {src_ff[AccWidth-2:0], 1'b0};
            step_in = step_ff + 6'd1;
            if (cv_ff == '0) begin
               q_in = '0;
               state_in = StMul1;
            end else if (step_ff == 6'(ValueWidth-1)) begin
               q_in = neg_ff ? -$signed({1'b0, quo_in[ValueWidth-1:0]})
                             :  $signed({1'b0, quo_in[ValueWidth-1:0]});
               state_in = StMul1;
            end
         end
         StMul1: begin
            mul_in = 33'(gain_ff * prior_ff);
            state_in = StMul2;
         end
         StMul2: begin
            src_in = AccWidth'(mul_ff * root_ff);
            src_in = {src_in[DivWidth-1:0], {(AccWidth-DivWidth){1'b0}}};
            dvs_in = AccWidth'({cv_ff + 21'd0 + 21'd1, 18'd0});
            rem_in = '0;
            quo_in = '0;
            step_in = '0;
            state_in = StEdiv;
         end
         StEdiv: begin
            rem_in = take ? trial : {rem_ff[AccWidth-2:0], src_ff[AccWidth-1]};
            quo_in = {quo_ff[AccWidth-2:0], take};
            src_in = {src_ff[AccWidth-2:0], 1'b0};
            step_in = step_ff + 6'd1;
            if (step_ff == 6'(DivWidth-1)) state_in = StSum;
         end
         StSum: begin
            state_in = StBest;
         end
         StBest: begin
            if (cnt_ff < CntMax) begin
               if (cnt_ff == '0 || score_ff > best_score_ff) begin
                  best_score_in = score_ff;
                  best_pos_in = cnt_ff;
               end
               cnt_in = cnt_ff + 1'b1;
            end
            state_in = StOut;
         end
         StOut: begin
            if (rsp_free) begin
               state_in = StIdle;
               if (last_ff) cnt_in = '0;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         gain_ff <= GainReset;
         cnt_ff <= '0;
         root_ff <= '0;
         best_score_ff <= '0;
         best_pos_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         root_ff <= root_in;
         best_score_ff <= best_score_in;
         best_pos_ff <= best_pos_in;
         if (csr_write_enable) gain_ff <= csr_write_data;
         if (state_ff == StOut && rsp_free) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      src_ff <= src_in;
      dvs_ff <= dvs_in;
      q_ff <= q_in;
      mul_ff <= mul_in;
      if (state_ff == StSum) score_ff <= score_in;
      if (req_valid && req_ready) begin
         cv_ff <= req_child_visits;
         neg_ff <= req_child_value_sum[ValueWidth-1];
         mag_ff <= req_child_value_sum[ValueWidth-1]
            ? ValueWidth'(-req_child_value_sum) : ValueWidth'(req_child_value_sum);
         prior_ff <= req_child_prior;
         last_ff <= req_last_child;
      end
      if (state_ff == StOut && rsp_free) begin
         rsp_score_ff <= score_ff;
         rsp_idx_ff <= last_ff ? IndexWidth'(best_pos_ff) : '0;
         rsp_bv_ff <= last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_child_score = rsp_score_ff;
   assign rsp_best_index = rsp_idx_ff;
   assign rsp_best_valid = rsp_bv_ff;

   `PCS_ASSERT_IMP(a_ready_idle, clock, reset, req_ready, state_ff == StIdle)
   `PCS_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && req_ready, !req_ready)
   `PCS_ASSERT_IMP(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CntMax)
   `PCS_ASSERT_NEXT(a_out_done, clock, reset, state_ff == StOut && rsp_free,
      rsp_valid && state_ff == StIdle)
endmodule

[verif/tb_puct_child_select.sv]
// testbench for puct_child_select: drives runs of child statistics, scores them
// with an in-bench predictor and checks every response field in order
// depends on pcs_pkg and the puct_child_select rtl
module tb_puct_child_select;
   import pcs_pkg::*;

   localparam int RunLimit = 512;
   localparam int Latency = 130;

   typedef struct packed {
      logic [VisitsWidth-1:0]       parent_visits;
      logic [VisitsWidth-1:0]       child_visits;
      logic signed [ValueWidth-1:0] child_sum;
      logic [PriorWidth-1:0]        prior;
      logic                         last_child;
   } child_type;

   typedef struct packed {
      logic signed [ScoreWidth-1:0] score;
      logic [IndexWidth-1:0]        best_index;
      logic                         best_valid;
   } score_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [GainWidth-1:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [VisitsWidth-1:0] req_parent_visits = '0;
   logic [VisitsWidth-1:0] req_child_visits = '0;
   logic signed [ValueWidth-1:0] req_child_value_sum = '0;
   logic [PriorWidth-1:0] req_child_prior = '0;
   logic req_last_child = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [ScoreWidth-1:0] rsp_child_score;
   logic [IndexWidth-1:0] rsp_best_index;
   logic rsp_best_valid;

   child_type pending_children[$];
   score_type expected_scores[$];
   int errors = 0;
   bit burst = 1'b0;   // no idling on either side while set
   bit hold_sender = 1'b0;

   // predictor state
   logic [GainWidth-1:0] gain = GainReset;
   logic signed [31:0] top_score = 0;
   int top_position = 0;
   int run_count = 0;
   logic [63:0] root_q6 = 0;

   always #6 clock = ~clock;

   puct_child_select u_dut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_parent_visits(req_parent_visits), .req_child_visits(req_child_visits),
      .req_child_value_sum(req_child_value_sum), .req_child_prior(req_child_prior),
      .req_last_child(req_last_child),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_child_score(rsp_child_score), .rsp_best_index(rsp_best_index),
      .rsp_best_valid(rsp_best_valid)
   );

   function automatic logic [63:0] isqrt(input logic [63:0] x);
      logic [63:0] r;
      r = 0;
      for (int b = 31; b >= 0; b--)
         if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= x) r = r | (64'd1 << b);
      return r;
   endfunction

   function automatic score_type score_child(input child_type c);
      score_type s;
      logic signed [63:0] q, total;
      logic [63:0] explore;
      q = 0;
      if (run_count == 0) root_q6 = isqrt({44'd0, c.parent_visits} << 12);
      if (c.child_visits != 0)
         q = 64'(signed'(c.child_sum)) / signed'({44'd0, c.child_visits});
      explore = (64'(gain) * 64'(c.prior) * root_q6) /
                ((64'(c.child_visits) + 64'd1) << 18);
      total = q + signed'(explore);
      if (total > 64'sd2147483647) s.score = 32'sh7fffffff;
      else if (total < -64'sd2147483648) s.score = 32'sh80000000;
      else s.score = total[31:0];
      if (run_count < RunLimit) begin
         if (run_count == 0 || s.score > top_score) begin
            top_score = s.score;
            top_position = run_count;
         end
         run_count++;
      end
      s.best_valid = c.last_child;
      s.best_index = c.last_child ? top_position[IndexWidth-1:0] : '0;
      if (c.last_child) run_count = 0;
      return s;
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (!req_valid || req_ready) begin
            if (pending_children.size() != 0 && !hold_sender &&
                (burst || $urandom_range(99) >= 25)) begin
               child_type c;
               c = pending_children.pop_front();
               expected_scores.insert(expected_scores.size(), score_child(c));
               req_valid <= 1'b1;
               req_parent_visits <= c.parent_visits;
               req_child_visits <= c.child_visits;
               req_child_value_sum <= c.child_sum;
               req_child_prior <= c.prior;
               req_last_child <= c.last_child;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= burst || $urandom_range(99) >= 25;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_scores.size() == 0) begin
            $error("unexpected transfer score=%0d", rsp_child_score);
            errors++;
         end else begin
            score_type e;
            e = expected_scores.pop_front();
            if (rsp_child_score !== e.score) begin
               $error("child_score expected %0d actual %0d", e.score, rsp_child_score);
               errors++;
            end
            if (rsp_best_index !== e.best_index) begin
               $error("best_index expected %0d actual %0d", e.best_index, rsp_best_index);
               errors++;
            end
            if (rsp_best_valid !== e.best_valid) begin
               $error("best_valid expected %0d actual %0d", e.best_valid, rsp_best_valid);
               errors++;
            end
         end
      end
   end

   function automatic child_type rand_child(input bit last);
      child_type c;
      c.parent_visits = VisitsWidth'($urandom);
      c.child_visits = ($urandom_range(3) == 0) ? VisitsWidth'($urandom)
                                                : VisitsWidth'($urandom_range(40));
      case ($urandom_range(3))
         0: c.child_sum = ValueWidth'({$urandom, $urandom});
         1: c.child_sum = ValueWidth'($signed($urandom_range(200000)) - 100000);
         default: c.child_sum = $signed({5'd0, $urandom}) >>> $urandom_range(20);
      endcase
      if ($urandom_range(1)) c.child_sum = -c.child_sum;
      c.prior = PriorWidth'($urandom_range(65536));
      if ($urandom_range(19) == 0) c.prior = PriorWidth'($urandom);
      c.last_child = last;
      return c;
   endfunction

   task automatic wait_drained();
      while (pending_children.size() != 0 || req_valid || expected_scores.size() != 0)
         @(posedge clock);
      repeat (Latency) @(posedge clock);
   endtask

   task automatic set_gain(input logic [GainWidth-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      gain = value;
   endtask

   task automatic add_run(input int len);
      for (int i = 0; i < len; i++)
         pending_children.insert(pending_children.size(), rand_child(i == len - 1));
   endtask

   initial begin
      child_type c;
      logic [GainWidth-1:0] gains[5];
      gains = '{16'hffff, 16'd0, 16'd1, 16'h8000, 16'd4096};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, unvisited, ties, prior above one
      c = '{parent_visits: '1, child_visits: 0, child_sum: '0, prior: 17'h10000,
            last_child: 0};
      pending_children.insert(pending_children.size(), c);
      c = '{parent_visits: 0, child_visits: '1, child_sum: {1'b0, {36{1'b1}}},
            prior: 17'h1ffff, last_child: 0};
      pending_children.insert(pending_children.size(), c);
      c = '{parent_visits: 0, child_visits: 1, child_sum: {1'b1, 36'd0},
            prior: 0, last_child: 0};
      pending_children.insert(pending_children.size(), c);
      c = '{parent_visits: 0, child_visits: 1, child_sum: {1'b0, {36{1'b1}}},
            prior: '1, last_child: 1};
      pending_children.insert(pending_children.size(), c);
      for (int i = 0; i < 4; i++) begin   // equal scores, first wins
         c = '{parent_visits: 100, child_visits: 3, child_sum: 37'sd3000,
               prior: 17'd20000, last_child: i == 3};
         pending_children.insert(pending_children.size(), c);
      end
      c = '{parent_visits: 1, child_visits: 0, child_sum: -37'sd5, prior: 0,
            last_child: 1};
      pending_children.insert(pending_children.size(), c);   // single-child run
      wait_drained();

      // overlong run: counter holds, later children do not compete
      burst = 1'b1;
      add_run(RunLimit + 3);
      wait_drained();
      burst = 1'b0;

      foreach (gains[g]) begin
         set_gain(gains[g]);
         for (int r = 0; r < 2; r++) add_run($urandom_range(1, 8));
         if (g == 2) begin
            while (expected_scores.size() == 0) @(posedge clock);
            hold_sender = 1'b1;
            while (req_valid || expected_scores.size() != 0) @(posedge clock);
            hold_sender = 1'b0;
         end
         if (g == 3) burst = 1'b1;
         wait_drained();
         burst = 1'b0;
      end

      if (errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   initial begin
      #(12 * 2000000);
      $display("Regression FAIL");
      $finish;
   end
endmodule
